FILE: rtl/r2q_pkg.sv
// Shared widths and types for the rotation matrix to quaternion block.
package r2q_pkg;
    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;
    localparam int SQ_W       = DATA_WIDTH + 5;    // signed scaled squares
    localparam int T_W        = DATA_WIDTH + 6;    // unsigned norm sum
    localparam int DIV_STEPS  = 2 * FRAC_BITS;
    localparam int Q_W        = 2 * FRAC_BITS + 1;
    localparam int SQRT_STEPS = FRAC_BITS + 1;
    localparam int ROOT_W     = FRAC_BITS + 1;
    localparam int VSQ_W      = 2 * SQRT_STEPS;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int LANE_LAT   = DIV_STEPS + SQRT_STEPS;
    localparam int IN_W       = 9 * DATA_WIDTH;
    localparam int OUT_W      = ((4 * DATA_WIDTH + 1 + 7) / 8) * 8;

    typedef struct packed {
        logic       vld;
        logic       zero;
        logic [2:0] neg;
    } meta_t;
endpackage

FILE: rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
//  Channel  Dir  Payload (tdata low bit up)                 Beat when
//  s_axis   in   r00 r01 r02 r10 r11 r12 r20 r21 r22 (16b)  s_tvalid & s_tready
//  m_axis   out  quat_w quat_x quat_y quat_z (16b), valid_res, pad
//                                                             m_tvalid & m_tready
//
// One beat in per cycle unless the output stalls. Data passes stages 1 and 2,
// the bit-per-stage divider and square root of each lane, then the output reg.
// rst_n clears all valid bits asynchronously; payload flops are not reset.
// A single enable moves the whole pipe; it holds when the output beat is
// waiting, so nothing is dropped or repeated.
module rotation_matrix_to_quaternion (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [r2q_pkg::IN_W-1:0]    s_tdata,  // r00,r01,r02,r10,r11,r12,r20,r21,r22
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [r2q_pkg::OUT_W-1:0]   m_tdata   // quat_w,quat_x,quat_y,quat_z,valid_res
);
    localparam int DW = r2q_pkg::DATA_WIDTH;
    localparam int SW = r2q_pkg::SQ_W;
    localparam int TW = r2q_pkg::T_W;
    localparam int RW = r2q_pkg::ROOT_W;
    localparam int LL = r2q_pkg::LANE_LAT;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // unpack matrix
    logic signed [DW-1:0] r [9];
    for (genvar k = 0; k < 9; k++) begin : g_unpack
        assign r[k] = s_tdata[k*DW +: DW];
    end

    // stage 1: scaled squares (4*q^2 in Q.F) and sign tests
    logic signed [SW-1:0] one_s;
    logic signed [SW-1:0] sw_c;
    logic signed [SW-1:0] sq_next [4];
    logic [2:0]           neg_next;
    assign one_s = SW'(1) <<< r2q_pkg::FRAC_BITS;
    assign sw_c  = SW'(r[0]) + SW'(r[4]) + SW'(r[8]) + one_s;
    assign sq_next[0] = sw_c;
    assign sq_next[1] = ((one_s + SW'(r[0])) <<< 1) - sw_c;
    assign sq_next[2] = ((one_s + SW'(r[4])) <<< 1) - sw_c;
    assign sq_next[3] = ((one_s + SW'(r[8])) <<< 1) - sw_c;
    assign neg_next[0] = (SW'(r[7]) - SW'(r[5])) < 0;
    assign neg_next[1] = (SW'(r[2]) - SW'(r[6])) < 0;
    assign neg_next[2] = (SW'(r[3]) - SW'(r[1])) < 0;

    logic signed [SW-1:0] sq1_reg [4];
    logic [2:0]           neg1_reg;
    logic                 vld1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg  <= sq_next;
            neg1_reg <= neg_next;
        end
    end

    // stage 2: clamp negatives, sum norm
    logic [TW-1:0] s2_next [4];
    logic [TW-1:0] t2_next;
    for (genvar k = 0; k < 4; k++) begin : g_clamp
        assign s2_next[k] = sq1_reg[k][SW-1] ? '0 : TW'(sq1_reg[k]);
    end
    assign t2_next = s2_next[0] + s2_next[1] + s2_next[2] + s2_next[3];

    logic [TW-1:0] s2_reg [4];
    logic [TW-1:0] t2_reg;
    logic [2:0]    neg2_reg;
    logic          vld2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg   <= s2_next;
            t2_reg   <= t2_next;
            neg2_reg <= neg1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
        end
    end

    // four divide/sqrt lanes
    logic [RW-1:0] mag [4];
    for (genvar k = 0; k < 4; k++) begin : g_lane
        r2q_lane u_lane (
            .clk   (clk),
            .en    (en),
            .s     (s2_reg[k]),
            .t     (t2_reg),
            .mag   (mag[k])
        );
    end

    // side-band delay matching the lanes
    r2q_pkg::meta_t meta_reg [LL];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LL; i++)
            begin
                meta_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            meta_reg[0] <= '{vld: vld2_reg, zero: (t2_reg == '0), neg: neg2_reg};
            for (int i = 1; i < LL; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    // output register: apply signs, zero-norm override
    logic [DW-1:0] q_next [4];
    for (genvar k = 0; k < 4; k++) begin : g_sign
        logic [DW-1:0] m;
        logic          n;
        assign m = DW'(mag[k]);
        if (k == 0) begin : g_w
            assign n = 1'b0;
        end
        else begin : g_xyz
            assign n = meta_reg[LL-1].neg[k-1];
        end
        assign q_next[k] = meta_reg[LL-1].zero ? '0 : (n ? DW'(-m) : m);
    end

    logic [DW-1:0] q_reg [4];
    logic          res_ok_reg;
    logic          m_tvalid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg      <= q_next;
            res_ok_reg <= !meta_reg[LL-1].zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= meta_reg[LL-1].vld;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = r2q_pkg::OUT_W'({res_ok_reg, q_reg[3], q_reg[2], q_reg[1], q_reg[0]});
endmodule

FILE: rtl/r2q_lane.sv
// One lane: pipelined floor(s*2^2F/t) followed by pipelined integer square root.
module r2q_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic [r2q_pkg::T_W-1:0]       s,
    input  logic [r2q_pkg::T_W-1:0]       t,
    output logic [r2q_pkg::ROOT_W-1:0]    mag
);
    localparam int DS = r2q_pkg::DIV_STEPS;
    localparam int SS = r2q_pkg::SQRT_STEPS;
    localparam int TW = r2q_pkg::T_W;
    localparam int QW = r2q_pkg::Q_W;
    localparam int RW = r2q_pkg::ROOT_W;
    localparam int VW = r2q_pkg::VSQ_W;
    localparam int EW = r2q_pkg::SREM_W;

    logic [TW-1:0] rem_reg  [DS];
    logic [TW-1:0] t_reg    [DS];
    logic [DS-1:0] q_reg    [DS];
    logic          full_reg [DS];

    logic [VW-1:0] v_reg    [SS];
    logic [EW-1:0] srem_reg [SS];
    logic [RW-1:0] root_reg [SS];

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DS; i++) begin : g_div
        logic [TW-1:0] rem_in;
        logic [TW-1:0] t_in;
        logic [DS-1:0] q_in;
        logic          full_in;
        logic [TW:0]   sh;
        logic          ge;
        if (i == 0) begin : g_first
            assign rem_in  = s;
            assign t_in    = t;
            assign q_in    = '0;
            assign full_in = (s == t);
        end
        else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign t_in    = t_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign full_in = full_reg[i-1];
        end
        assign sh = {rem_in, 1'b0};
        assign ge = (sh >= {1'b0, t_in});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? TW'(sh - {1'b0, t_in}) : sh[TW-1:0];
                t_reg[i]    <= t_in;
                q_reg[i]    <= {q_in[DS-2:0], ge};
                full_reg[i] <= full_in;
            end
        end
    end

    logic [QW-1:0] quo;
    assign quo = full_reg[DS-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, q_reg[DS-1]};

    // digit-by-digit square root, one root bit per stage
    for (genvar j = 0; j < SS; j++) begin : g_sqrt
        logic [VW-1:0] v_in;
        logic [EW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [EW-1:0] rem2;
        logic [EW-1:0] trial;
        logic          ge;
        if (j == 0) begin : g_first
            assign v_in    = VW'(quo);
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = srem_reg[j-1];
            assign root_in = root_reg[j-1];
        end
        assign rem2  = {rem_in[EW-3:0], v_in[VW-1 -: 2]};
        assign trial = EW'({root_in, 2'b01});
        assign ge    = (rem2 >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j]    <= {v_in[VW-3:0], 2'b00};
                srem_reg[j] <= ge ? rem2 - trial : rem2;
                root_reg[j] <= {root_in[RW-2:0], ge};
            end
        end
    end

    assign mag = root_reg[SS-1];
endmodule
